// ===== src/sh64_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sh64_pkg;

  localparam logic [63:0] PR1 = 64'd11400714785074694791;
  localparam logic [63:0] PR2 = 64'd14029467366897019727;
  localparam logic [63:0] PR3 = 64'd1609587929392839161;
  localparam logic [63:0] PR4 = 64'd9650029242287828579;
  localparam logic [63:0] PR5 = 64'd2870177450012600261;

  localparam int unsigned FifoDepth = 2;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        last;
  } item_t;

  // Rotate left by a constant amount between 1 and 63.
  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

endpackage
`default_nettype wire

// ===== src/sh64_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sh64_front #(
  parameter int unsigned Depth = sh64_pkg::FifoDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [63:0]       data_word_i,
  input  wire logic [3:0]        byte_count_i,
  input  wire logic              last_word_i,
  output logic                   item_valid_o,
  output sh64_pkg::item_t        item_o,
  input  wire logic              item_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sh64_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  sh64_pkg::item_t push_item;

  // A count above eight is handled as a full word.
  always_comb begin
    push_item.word = data_word_i;
    push_item.cnt  = byte_count_i[3] ? 4'd8 : byte_count_i;
    push_item.last = last_word_i;
  end

  assign in_ready_o   = (cnt_q != CntW'(Depth));
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (item_pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !item_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && item_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== src/sh64_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sh64_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      p_o
);

  // Low 64 bits of a 64 by 64 product, one 32 by 32 partial product a cycle.
  logic [63:0] a_q, b_q, acc_q;
  logic [1:0]  step_q;
  logic        done_q;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  always_comb begin
    case (step_q)
      2'd1: begin
        ma = a_q[31:0];
        mb = b_q[31:0];
      end
      2'd2: begin
        ma = a_q[31:0];
        mb = b_q[63:32];
      end
      default: begin
        ma = a_q[63:32];
        mb = b_q[31:0];
      end
    endcase
  end

  assign prod   = ma * mb;
  assign done_o = done_q;
  assign p_o    = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_q <= 1'b0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= a_i;
        b_q    <= b_i;
        step_q <= 2'd1;
      end else begin
        case (step_q)
          2'd1: begin
            acc_q  <= prod;
            step_q <= 2'd2;
          end
          2'd2: begin
            acc_q  <= acc_q + {prod[31:0], 32'd0};
            step_q <= 2'd3;
          end
          2'd3: begin
            acc_q  <= acc_q + {prod[31:0], 32'd0};
            step_q <= 2'd0;
            done_q <= 1'b1;
          end
          default: step_q <= 2'd0;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/sh64_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sh64_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [63:0]     seed_i,
  input  wire logic            item_valid_i,
  input  sh64_pkg::item_t      item_i,
  output logic                 item_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [63:0]          hash_value_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_APPEND, S_ABS_INIT, S_ABS_M1, S_ABS_M2, S_ABS_W,
    S_FIN_BASE, S_MRG_M1, S_MRG_M2, S_MRG_X, S_MRG_A, S_FIN_LEN,
    S_TAIL, S_T8_2, S_T8_3, S_T8_4, S_T4_2, S_T4_3, S_T1_2, S_T1_3,
    S_AV1, S_AV2, S_AV3, S_WAIT
  } state_e;

  state_e           state_q, state_d, ret_q, ret_d;
  logic [63:0]      word_q, word_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             last_q, last_d;
  logic [255:0]     buf_q, buf_d;
  logic [5:0]       fill_q, fill_d;
  logic [63:0]      len_q, len_d;
  logic             seen_q, seen_d;
  logic [3:0][63:0] lane_q, lane_d;
  logic [1:0]       idx_q, idx_d;
  logic [63:0]      h_q, h_d;
  logic [5:0]       pos_q, pos_d;
  logic [63:0]      out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             mul_start, mul_done;
  logic [63:0]      mul_a, mul_b, mul_p;

  logic [5:0]       space;
  logic [3:0]       app_n;
  logic [255:0]     app_buf;
  logic [63:0]      app_word;
  logic [63:0]      tail_word, hx;
  logic [7:0]       tail_byte;

  sh64_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // Places as many bytes of the word as fit before the stripe is full.
  always_comb begin
    logic [5:0] k;
    space    = 6'd32 - fill_q;
    app_n    = ({2'b00, cnt_q} < space) ? cnt_q : space[3:0];
    app_buf  = buf_q;
    app_word = word_q >> {app_n, 3'b000};
    for (int j = 0; j < 32; j++) begin
      k = 6'(j) - fill_q;
      if ((6'(j) >= fill_q) && (k < {2'b00, app_n})) begin
        app_buf[j*8 +: 8] = word_q[k[2:0]*8 +: 8];
      end
    end
  end

  assign tail_word = buf_q[pos_q[4:3]*64 +: 64];
  assign tail_byte = buf_q[pos_q[4:0]*8 +: 8];
  assign hx        = h_q ^ mul_p;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    word_d      = word_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    buf_d       = buf_q;
    fill_d      = fill_q;
    len_d       = len_q;
    seen_d      = seen_q;
    lane_d      = lane_q;
    idx_d       = idx_q;
    h_d         = h_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    item_pop_o  = 1'b0;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          word_d     = item_i.word;
          cnt_d      = item_i.cnt;
          last_d     = item_i.last;
          state_d    = S_APPEND;
        end
      end
      S_APPEND: begin
        buf_d  = app_buf;
        fill_d = fill_q + {2'b00, app_n};
        len_d  = len_q + {60'd0, app_n};
        word_d = app_word;
        cnt_d  = cnt_q - app_n;
        if ((fill_q + {2'b00, app_n}) == 6'd32) begin
          state_d = S_ABS_INIT;
        end else if (last_q) begin
          state_d = S_FIN_BASE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ABS_INIT: begin
        if (!seen_q) begin
          lane_d[0] = seed_i + sh64_pkg::PR1 + sh64_pkg::PR2;
          lane_d[1] = seed_i + sh64_pkg::PR2;
          lane_d[2] = seed_i;
          lane_d[3] = seed_i - sh64_pkg::PR1;
        end
        seen_d  = 1'b1;
        idx_d   = 2'd0;
        state_d = S_ABS_M1;
      end
      S_ABS_M1: begin
        mul_start = 1'b1;
        mul_a     = buf_q[idx_q*64 +: 64];
        mul_b     = sh64_pkg::PR2;
        ret_d     = S_ABS_M2;
        state_d   = S_WAIT;
      end
      S_ABS_M2: begin
        mul_start = 1'b1;
        mul_a     = sh64_pkg::rotl(lane_q[idx_q] + mul_p, 31);
        mul_b     = sh64_pkg::PR1;
        ret_d     = S_ABS_W;
        state_d   = S_WAIT;
      end
      S_ABS_W: begin
        lane_d[idx_q] = mul_p;
        if (idx_q == 2'd3) begin
          fill_d  = 6'd0;
          state_d = S_APPEND;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_ABS_M1;
        end
      end
      S_FIN_BASE: begin
        if (seen_q) begin
          h_d = sh64_pkg::rotl(lane_q[0], 1) + sh64_pkg::rotl(lane_q[1], 7)
              + sh64_pkg::rotl(lane_q[2], 12) + sh64_pkg::rotl(lane_q[3], 18);
          idx_d   = 2'd0;
          state_d = S_MRG_M1;
        end else begin
          h_d     = seed_i + sh64_pkg::PR5;
          state_d = S_FIN_LEN;
        end
      end
      S_MRG_M1: begin
        mul_start = 1'b1;
        mul_a     = lane_q[idx_q];
        mul_b     = sh64_pkg::PR2;
        ret_d     = S_MRG_M2;
        state_d   = S_WAIT;
      end
      S_MRG_M2: begin
        mul_start = 1'b1;
        mul_a     = sh64_pkg::rotl(mul_p, 31);
        mul_b     = sh64_pkg::PR1;
        ret_d     = S_MRG_X;
        state_d   = S_WAIT;
      end
      S_MRG_X: begin
        mul_start = 1'b1;
        mul_a     = hx;
        mul_b     = sh64_pkg::PR1;
        ret_d     = S_MRG_A;
        state_d   = S_WAIT;
      end
      S_MRG_A: begin
        h_d = mul_p + sh64_pkg::PR4;
        if (idx_q == 2'd3) begin
          state_d = S_FIN_LEN;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_MRG_M1;
        end
      end
      S_FIN_LEN: begin
        h_d     = h_q + len_q;
        pos_d   = 6'd0;
        state_d = S_TAIL;
      end
      S_TAIL: begin
        if ((pos_q + 6'd8) <= fill_q) begin
          mul_start = 1'b1;
          mul_a     = tail_word;
          mul_b     = sh64_pkg::PR2;
          ret_d     = S_T8_2;
          state_d   = S_WAIT;
        end else if ((pos_q + 6'd4) <= fill_q) begin
          mul_start = 1'b1;
          mul_a     = {32'd0, tail_word[31:0]};
          mul_b     = sh64_pkg::PR1;
          ret_d     = S_T4_2;
          state_d   = S_WAIT;
        end else if (pos_q < fill_q) begin
          mul_start = 1'b1;
          mul_a     = {56'd0, tail_byte};
          mul_b     = sh64_pkg::PR5;
          ret_d     = S_T1_2;
          state_d   = S_WAIT;
        end else begin
          state_d = S_AV1;
        end
      end
      S_T8_2: begin
        mul_start = 1'b1;
        mul_a     = sh64_pkg::rotl(mul_p, 31);
        mul_b     = sh64_pkg::PR1;
        ret_d     = S_T8_3;
        state_d   = S_WAIT;
      end
      S_T8_3: begin
        mul_start = 1'b1;
        mul_a     = sh64_pkg::rotl(hx, 27);
        mul_b     = sh64_pkg::PR1;
        ret_d     = S_T8_4;
        state_d   = S_WAIT;
      end
      S_T8_4: begin
        h_d     = mul_p + sh64_pkg::PR4;
        pos_d   = pos_q + 6'd8;
        state_d = S_TAIL;
      end
      S_T4_2: begin
        mul_start = 1'b1;
        mul_a     = sh64_pkg::rotl(hx, 23);
        mul_b     = sh64_pkg::PR2;
        ret_d     = S_T4_3;
        state_d   = S_WAIT;
      end
      S_T4_3: begin
        h_d     = mul_p + sh64_pkg::PR3;
        pos_d   = pos_q + 6'd4;
        state_d = S_TAIL;
      end
      S_T1_2: begin
        mul_start = 1'b1;
        mul_a     = sh64_pkg::rotl(hx, 11);
        mul_b     = sh64_pkg::PR1;
        ret_d     = S_T1_3;
        state_d   = S_WAIT;
      end
      S_T1_3: begin
        h_d     = mul_p;
        pos_d   = pos_q + 6'd1;
        state_d = S_TAIL;
      end
      S_AV1: begin
        mul_start = 1'b1;
        mul_a     = h_q ^ (h_q >> 33);
        mul_b     = sh64_pkg::PR2;
        ret_d     = S_AV2;
        state_d   = S_WAIT;
      end
      S_AV2: begin
        mul_start = 1'b1;
        mul_a     = mul_p ^ (mul_p >> 29);
        mul_b     = sh64_pkg::PR3;
        ret_d     = S_AV3;
        state_d   = S_WAIT;
      end
      S_AV3: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = mul_p ^ (mul_p >> 32);
          out_valid_d = 1'b1;
          fill_d      = 6'd0;
          len_d       = '0;
          seen_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      S_WAIT: begin
        if (mul_done) begin
          state_d = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      fill_q      <= '0;
      len_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    buf_q  <= buf_d;
    lane_q <= lane_d;
    h_q    <= h_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

// ===== src/stream_hash_64.sv =====
// 64-bit xxHash of a message streamed as little-endian 64-bit words.
// The input channel takes one word per request with its valid byte count and a
// last flag; only the last word may be partial, and an empty message is one
// last word with a count of zero. The output channel gives one hash per message.
// The seed is written through its own channel; the user must write it only while
// the block is idle, as the block does not enforce this. A two-entry queue
// takes requests while the engine works. A non-last word that does not close a
// 32-byte stripe is only popped and appended. Every multiply runs on one shared
// 32-bit multiplier as three partial products; a closed stripe takes two per lane,
// the message end three per lane to merge (none if no stripe was seen), three per
// 8-byte tail piece, two per 4-byte piece or byte and two for the avalanche.
// Reset clears the queue, the engine state and the seed to zero.
// When the receiver stalls, the finished hash is held in the output register,
// the engine keeps absorbing the next message and waits only if it finishes
// another hash before the first one is taken.
`timescale 1ns / 1ps
`default_nettype none
module stream_hash_64 #(
  parameter int unsigned FifoDepth = sh64_pkg::FifoDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] data_word_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic        last_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      hash_value_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [63:0] cfg_data_i
);

  logic            item_valid, item_pop;
  sh64_pkg::item_t item;
  logic [63:0]     seed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i) begin
      seed_q <= cfg_data_i;
    end
  end

  sh64_front #(
    .Depth (FifoDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  sh64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

endmodule
`default_nettype wire
